@@ src/fevad_pkg.sv @@
package fevad_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SQUARE_W    = 31;
   localparam int ENERGY_W    = 40;
   localparam int THRESH_W    = 31;
   localparam int HANG_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int FRAME_MAX_DEFAULT = 480;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(53687);
   localparam logic [HANG_W-1:0]   HANG_RESET   = HANG_W'(50);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_HANGOVER  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_W-1:0] threshold;
      logic [HANG_W-1:0]   hangover;
   } csr_type;

endpackage

@@ src/frame_energy_voice_activity.sv @@
// A frame-closing sample passes registers s1, s2, frame-end, bound and rsp_valid.
// Throughput: one sample per cycle unless held; energy sum and count accumulate
// once per valid sample, the threshold product is one pipelined multiplier.
// The whole pipeline holds while a result waits on rsp_ready.
// Reset (synchronous): empties the pipeline, clears energy, count, speaking
// and quiet-frame state, and loads threshold 53687 and hangover 50.
module frame_energy_voice_activity
   import fevad_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_of_frame,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_speaking,
   output logic                       rsp_changed,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(FRAME_MAX + 1);

   csr_type             csr_ff;
   logic                advance;
   logic                frame_valid;
   logic [ENERGY_W-1:0] frame_energy;
   logic [CNT_W-1:0]    frame_count;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.threshold <= THRESH_RESET;
         csr_ff.hangover  <= HANG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: csr_ff.threshold <= csr_wdata[THRESH_W-1:0];
            CSR_HANGOVER:  csr_ff.hangover  <= csr_wdata[HANG_W-1:0];
            default: ;
         endcase
      end
   end

   fevad_accum #(
      .FRAME_MAX (FRAME_MAX),
      .CNT_W     (CNT_W)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_sample    (req_sample),
      .in_last      (req_last_of_frame),
      .frame_valid  (frame_valid),
      .frame_energy (frame_energy),
      .frame_count  (frame_count)
   );

   fevad_decide #(
      .CNT_W (CNT_W)
   ) u_decide (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .csr          (csr_ff),
      .frame_valid  (frame_valid),
      .frame_energy (frame_energy),
      .frame_count  (frame_count),
      .out_valid    (rsp_valid),
      .out_speaking (rsp_speaking),
      .out_changed  (rsp_changed)
   );

endmodule

@@ src/fevad_accum.sv @@
module fevad_accum
   import fevad_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEFAULT,
   parameter int CNT_W     = $clog2(FRAME_MAX + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   input  logic                       in_last,
   output logic                       frame_valid,
   output logic [ENERGY_W-1:0]        frame_energy,
   output logic [CNT_W-1:0]           frame_count
);

   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(FRAME_MAX);

   logic                       s1_valid_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       s1_last_ff;

   logic                       s2_valid_ff;
   logic [SQUARE_W-1:0]        s2_square_ff;
   logic                       s2_last_ff;

   logic [ENERGY_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       end_valid_ff;
   logic [ENERGY_W-1:0]        end_energy_ff;
   logic [CNT_W-1:0]           end_count_ff;

   logic signed [2*SAMPLE_W-1:0] product;
   logic [ENERGY_W:0]            sum_add;
   logic                         frame_end;

   assign product = s1_sample_ff * s1_sample_ff;

   always_comb begin
      sum_add = {1'b0, sum_ff} + (ENERGY_W + 1)'(s2_square_ff);
      sum_in = sum_add[ENERGY_W] ? {ENERGY_W{1'b1}} : sum_add[ENERGY_W-1:0];
      count_in = count_ff + 1'b1;
      frame_end = s2_last_ff || (count_in == COUNT_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         end_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         end_valid_ff <= s2_valid_ff && frame_end;
         if (s2_valid_ff) begin
            if (frame_end) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               count_ff <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff  <= in_sample;
         s1_last_ff    <= in_last;
         s2_square_ff  <= product[SQUARE_W-1:0];
         s2_last_ff    <= s1_last_ff;
         end_energy_ff <= sum_in;
         end_count_ff  <= count_in;
      end
   end

   assign frame_valid  = end_valid_ff;
   assign frame_energy = end_energy_ff;
   assign frame_count  = end_count_ff;

endmodule

@@ src/fevad_decide.sv @@
module fevad_decide
   import fevad_pkg::*;
#(
   parameter int CNT_W = $clog2(FRAME_MAX_DEFAULT + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  csr_type             csr,
   input  logic                frame_valid,
   input  logic [ENERGY_W-1:0] frame_energy,
   input  logic [CNT_W-1:0]    frame_count,
   output logic                out_valid,
   output logic                out_speaking,
   output logic                out_changed
);

   localparam int PROD_W = THRESH_W + CNT_W;
   localparam int CMP_W  = (PROD_W > ENERGY_W) ? PROD_W : ENERGY_W;

   logic                p_valid_ff;
   logic [PROD_W-1:0]   p_bound_ff;
   logic [ENERGY_W-1:0] p_energy_ff;

   logic                speaking_ff, speaking_in;
   logic [HANG_W-1:0]   quiet_ff, quiet_in;
   logic                changed_in;
   logic                rsp_valid_ff;
   logic                rsp_speaking_ff;
   logic                rsp_changed_ff;

   logic                quiet;
   logic [HANG_W-1:0]   quiet_next;

   always_comb begin
      quiet       = CMP_W'(p_energy_ff) < CMP_W'(p_bound_ff);
      quiet_next  = quiet_ff + 1'b1;
      speaking_in = speaking_ff;
      quiet_in    = quiet_ff;
      changed_in  = 1'b0;
      if (quiet) begin
         if (speaking_ff) begin
            quiet_in = quiet_next;
            if (quiet_next >= csr.hangover) begin
               speaking_in = 1'b0;
               changed_in  = 1'b1;
               quiet_in    = '0;
            end
         end
      end else begin
         quiet_in = '0;
         if (!speaking_ff) begin
            speaking_in = 1'b1;
            changed_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         speaking_ff  <= 1'b0;
         quiet_ff     <= '0;
      end else if (advance) begin
         p_valid_ff   <= frame_valid;
         rsp_valid_ff <= p_valid_ff;
         if (p_valid_ff) begin
            speaking_ff <= speaking_in;
            quiet_ff    <= quiet_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_bound_ff  <= PROD_W'(csr.threshold) * PROD_W'(frame_count);
         p_energy_ff <= frame_energy;
         if (p_valid_ff) begin
            rsp_speaking_ff <= speaking_in;
            rsp_changed_ff  <= changed_in;
         end
      end
   end

   assign out_valid    = rsp_valid_ff;
   assign out_speaking = rsp_speaking_ff;
   assign out_changed  = rsp_changed_ff;

endmodule
